### rtl/bdae_pkg.sv
// shared types and constants for the binary to decimal ascii emitter
package bdae_pkg;

   localparam int ValueWidth = 32;
   localparam int NumDigits  = 10;
   localparam int BcdWidth   = 4 * NumDigits;
   localparam int StepWidth  = $clog2(ValueWidth);
   localparam int CountWidth = $clog2(NumDigits + 1);
   localparam int CharWidth  = 6;

   localparam logic [CharWidth-1:0] AsciiZero = 6'h30;
   localparam logic [3:0] DigitAdjustLimit = 4'd5;
   localparam logic [3:0] DigitAdjust      = 4'd3;

   typedef enum logic [3:0] {
      StIdle    = 4'b0001,
      StConvert = 4'b0010,
      StEmit    = 4'b0100,
      StRefuse  = 4'b1000
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic skip;
      logic emit;
      logic refuse;
   } cmd_type;

   typedef struct packed {
      logic port_open;
      logic conv_last;
      logic out_free;
      logic scan_skip;
      logic scan_final;
   } status_type;

endpackage

### rtl/bdae_datapath.sv
// conversion registers, digit scan and output register of the emitter
module bdae_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bdae_pkg::cmd_type                    cmd,
   output bdae_pkg::status_type                 status,
   input  logic [bdae_pkg::ValueWidth-1:0]      req_value,
   input  logic                                 csr_valid,
   input  logic                                 csr_data,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic [bdae_pkg::CharWidth-1:0]       rsp_char,
   output logic                                 rsp_accepted,
   output logic                                 rsp_last
);

   logic                                  port_open_ff;
   logic [bdae_pkg::ValueWidth-1:0]       bin_ff, bin_in;
   logic [bdae_pkg::BcdWidth-1:0]         bcd_ff, bcd_in;
   logic [bdae_pkg::BcdWidth-1:0]         bcd_adj;
   logic [bdae_pkg::StepWidth-1:0]        step_ff, step_in;
   logic [bdae_pkg::CountWidth-1:0]       remaining_ff, remaining_in;
   logic                                  started_ff, started_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [bdae_pkg::CharWidth-1:0]        rsp_char_ff, rsp_char_in;
   logic                                  rsp_accepted_ff, rsp_accepted_in;
   logic                                  rsp_last_ff, rsp_last_in;
   logic [3:0]                            top_digit;
   logic                                  out_free;

   assign top_digit = bcd_ff[bdae_pkg::BcdWidth-1 -: 4];
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // add three to every digit of five or more before the shift
   always_comb begin
      for (int i = 0; i < bdae_pkg::NumDigits; i++) begin
         if (bcd_ff[i*4 +: 4] >= bdae_pkg::DigitAdjustLimit) begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4] + bdae_pkg::DigitAdjust;
         end else begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4];
         end
      end
   end

   always_comb begin
      bin_in          = bin_ff;
      bcd_in          = bcd_ff;
      step_in         = step_ff;
      remaining_in    = remaining_ff;
      started_in      = started_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_char_in     = rsp_char_ff;
      rsp_accepted_in = rsp_accepted_ff;
      rsp_last_in     = rsp_last_ff;
      if (cmd.load) begin
         bin_in       = req_value;
         bcd_in       = '0;
         step_in      = '0;
         remaining_in = bdae_pkg::CountWidth'(bdae_pkg::NumDigits);
         started_in   = 1'b0;
      end
      if (cmd.step) begin
         bcd_in  = {bcd_adj[bdae_pkg::BcdWidth-2:0], bin_ff[bdae_pkg::ValueWidth-1]};
         bin_in  = {bin_ff[bdae_pkg::ValueWidth-2:0], 1'b0};
         step_in = step_ff + 1'b1;
      end
      if (cmd.skip || cmd.emit) begin
         bcd_in       = {bcd_ff[bdae_pkg::BcdWidth-5:0], 4'b0000};
         remaining_in = remaining_ff - 1'b1;
      end
      if (cmd.emit) begin
         started_in      = 1'b1;
         rsp_valid_in    = 1'b1;
         rsp_char_in     = {2'b00, top_digit} + bdae_pkg::AsciiZero;
         rsp_accepted_in = 1'b1;
         rsp_last_in     = (remaining_ff == bdae_pkg::CountWidth'(1));
      end
      if (cmd.refuse) begin
         rsp_valid_in    = 1'b1;
         rsp_char_in     = '0;
         rsp_accepted_in = 1'b0;
         rsp_last_in     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         port_open_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         started_ff   <= 1'b0;
         step_ff      <= '0;
         remaining_ff <= '0;
      end else begin
         if (csr_valid) begin
            port_open_ff <= csr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
         started_ff   <= started_in;
         step_ff      <= step_in;
         remaining_ff <= remaining_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff          <= bin_in;
      bcd_ff          <= bcd_in;
      rsp_char_ff     <= rsp_char_in;
      rsp_accepted_ff <= rsp_accepted_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign status.port_open  = port_open_ff;
   assign status.conv_last  = (step_ff == bdae_pkg::StepWidth'(bdae_pkg::ValueWidth - 1));
   assign status.out_free   = out_free;
   assign status.scan_final = (remaining_ff == bdae_pkg::CountWidth'(1));
   assign status.scan_skip  = !started_ff && (top_digit == 4'd0) && !status.scan_final;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_char     = rsp_char_ff;
   assign rsp_accepted = rsp_accepted_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

### rtl/bdae_controller.sv
// state machine sequencing load, conversion steps and digit emission
module bdae_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  bdae_pkg::status_type status,
   output bdae_pkg::cmd_type    cmd
);

   bdae_pkg::state_type state_ff, state_in;

   assign req_ready = (state_ff == bdae_pkg::StIdle);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         bdae_pkg::StIdle: begin
            if (req_valid) begin
               if (status.port_open) begin
                  cmd.load = 1'b1;
                  state_in = bdae_pkg::StConvert;
               end else begin
                  state_in = bdae_pkg::StRefuse;
               end
            end
         end
         bdae_pkg::StConvert: begin
            cmd.step = 1'b1;
            if (status.conv_last) begin
               state_in = bdae_pkg::StEmit;
            end
         end
         bdae_pkg::StEmit: begin
            if (status.scan_skip) begin
               cmd.skip = 1'b1;
            end else if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.scan_final) begin
                  state_in = bdae_pkg::StIdle;
               end
            end
         end
         bdae_pkg::StRefuse: begin
            if (status.out_free) begin
               cmd.refuse = 1'b1;
               state_in   = bdae_pkg::StIdle;
            end
         end
         default: begin
            state_in = bdae_pkg::StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bdae_pkg::StIdle;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/binary_to_decimal_ascii_emitter.sv
// top level: unsigned 32-bit number in, decimal ascii digits out
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  tdata[31:0] value
//   rsp      out        rsp_tvalid/rsp_tready  tdata[5:0] digit_char, tuser accepted, tlast
//   csr      in         csr_valid/csr_ready    csr_data port_open
//
// a request is accepted, shifted through all 32 bits with shift-add-3, then the
// ten digit positions are scanned one by one, leading zeros skipped
// a closed port answers a taken request with one refused response once the output is free
// reset is synchronous; it closes the port and empties the output register
// a stalled response holds the digit scan; only leading zeros are skipped meanwhile
module binary_to_decimal_ascii_emitter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // value[31:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // digit_char[5:0], zero[7:6]
   output logic [0:0]  rsp_tuser,   // accepted[0]
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data
);

   bdae_pkg::cmd_type    cmd;
   bdae_pkg::status_type status;
   logic [bdae_pkg::CharWidth-1:0] rsp_char;
   logic                            rsp_accepted;

   assign csr_ready = 1'b1;

   bdae_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   bdae_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_value    (req_tdata),
      .csr_valid    (csr_valid && csr_ready),
      .csr_data     (csr_data),
      .rsp_ready    (rsp_tready),
      .rsp_valid    (rsp_tvalid),
      .rsp_char     (rsp_char),
      .rsp_accepted (rsp_accepted),
      .rsp_last     (rsp_tlast)
   );

   assign rsp_tdata = {2'b00, rsp_char};
   assign rsp_tuser = rsp_accepted;

   a_refused_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast && (rsp_tdata == 8'd0))
      else $error("refused response must be a single zero response");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> (rsp_tdata >= 8'd48) && (rsp_tdata <= 8'd57))
      else $error("accepted response carries a non-digit character");

   a_no_request_while_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while previous one still in progress");

endmodule

### tb/tb_top.sv
// testbench for the binary to decimal ascii emitter: scoreboard, drivers and checks
`timescale 1ns / 1ps

class digit_scoreboard;

   typedef struct packed {
      logic [bdae_pkg::CharWidth-1:0] digit_char;
      logic                           accepted;
      logic                           last;
   } digit_rsp_type;

   digit_rsp_type pending_chars[$];
   logic          port_open;
   int            errors;

   function new();
      port_open = 1'b0;
      errors    = 0;
   endfunction

   function int pending();
      return pending_chars.size();
   endfunction

   task report(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
   endtask

   function void set_port_open(input logic open_bit);
      port_open = open_bit;
   endfunction

   // split the value into decimal digits, most significant first, or note one refused response when the port is closed
   function void note_value(input logic [bdae_pkg::ValueWidth-1:0] value);
      digit_rsp_type                   item;
      logic [3:0]                      digs[bdae_pkg::NumDigits];
      logic [bdae_pkg::ValueWidth-1:0] rest;
      int                              n;
      if (!port_open) begin
         item.digit_char = '0;
         item.accepted   = 1'b0;
         item.last       = 1'b1;
         pending_chars.push_back(item);
         return;
      end
      rest = value;
      n    = 0;
      do begin
         digs[n] = 4'(rest % 10);
         rest    = rest / 10;
         n++;
      end while (rest != 0 && n < bdae_pkg::NumDigits);
      for (int k = 0; k < n; k++) begin
         item.digit_char = bdae_pkg::AsciiZero + bdae_pkg::CharWidth'(digs[n - 1 - k]);
         item.accepted   = 1'b1;
         item.last       = (k == n - 1);
         pending_chars.push_back(item);
      end
   endfunction

   task check_rsp(input logic [7:0] tdata, input logic accepted, input logic last);
      digit_rsp_type want;
      if (pending_chars.size() == 0) begin
         report($sformatf("unexpected response tdata=%0h accepted=%0b last=%0b",
                          tdata, accepted, last));
         return;
      end
      want = pending_chars.pop_front();
      if (tdata !== {2'b00, want.digit_char})
         report($sformatf("digit_char got %0h want %0h", tdata, want.digit_char));
      if (accepted !== want.accepted)
         report($sformatf("accepted got %0b want %0b", accepted, want.accepted));
      if (last !== want.last)
         report($sformatf("last got %0b want %0b", last, want.last));
   endtask

endclass

module tb_top;

   localparam int CycleLimit = 400000;
   localparam int DrainCycles = 60;
   localparam int HoldCycles  = 300;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_data;

   logic idle_en  = 1'b1;
   logic hold_req = 1'b0;
   int   cycles   = 0;

   digit_scoreboard sb;

   binary_to_decimal_ascii_emitter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_rsp(rsp_tdata, rsp_tuser[0], rsp_tlast);
   end

   // receiver with random stalls and one long hold-off
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_tready = 1'b0;
            repeat (HoldCycles) @(posedge clock);
            hold_req = 1'b0;
         end else if (idle_en && $urandom_range(0, 2) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 8) - 1) @(negedge clock);
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   function automatic logic [31:0] pick_value();
      int unsigned sel;
      int unsigned span;
      int          k;
      sel  = $urandom_range(0, 9);
      k    = $urandom_range(1, 9);
      span = 1;
      repeat (k) span = span * 10;
      case (sel)
         0, 1, 2, 3: return $urandom;
         4, 5, 6:    return $urandom_range(0, span - 1);
         7:          return ($urandom_range(0, 1) == 1) ? span : span - 1;
         8:          return $urandom_range(0, 20);
         default:    return 32'hFFFF_FFFF - $urandom_range(0, 1000);
      endcase
   endfunction

   task automatic send_value(input logic [31:0] value);
      if (idle_en && $urandom_range(0, 3) == 0) begin
         req_tvalid = 1'b0;
         req_tdata  = $urandom;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = value;
      do @(posedge clock); while (!req_tready);
      sb.note_value(value);
      @(negedge clock);
   endtask

   task automatic send_random(input int count);
      repeat (count) send_value(pick_value());
   endtask

   task automatic wait_idle();
      req_tvalid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_port_open(input logic open_bit);
      csr_valid = 1'b1;
      csr_data  = open_bit;
      do @(posedge clock); while (!csr_ready);
      sb.set_port_open(open_bit);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   initial begin
      sb         = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_data   = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // port closed out of reset
      send_value(32'd0);
      send_value(32'hFFFF_FFFF);
      send_value($urandom);
      wait_idle();

      write_port_open(1'b1);
      send_value(32'd0);
      send_value(32'd1);
      send_value(32'd9);
      send_value(32'd10);
      send_value(32'd99);
      send_value(32'd100);
      send_value(32'd999_999_999);
      send_value(32'd1_000_000_000);
      send_value(32'hFFFF_FFFE);
      send_value(32'hFFFF_FFFF);
      send_value(32'h8000_0000);
      send_value(32'h7FFF_FFFF);
      send_value(32'h5555_5555);
      send_value(32'hAAAA_AAAA);
      wait_idle();

      write_port_open(1'b0);
      send_value(32'd0);
      send_value(32'hAAAA_AAAA);
      send_value(32'h5555_5555);
      wait_idle();

      write_port_open(1'b1);
      send_random(20);
      hold_req = 1'b1;
      send_random(30);
      wait_idle();

      write_port_open(1'b0);
      send_random(8);
      wait_idle();

      write_port_open(1'b1);
      idle_en = 1'b0;
      send_random(25);
      wait_idle();

      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

### filelist.f
rtl/bdae_pkg.sv
rtl/bdae_datapath.sv
rtl/bdae_controller.sv
rtl/binary_to_decimal_ascii_emitter.sv
tb/tb_top.sv
